// ===== src/plt_pkg.sv =====
// Shared types and constants for the pump and light cycle timer.
`default_nettype none

package plt_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DAY_HOURS   = 3'd0,
    CFG_PIPE_OFF    = 3'd1,
    CFG_PIPE_ON     = 3'd2,
    CFG_POOL_OFF    = 3'd3,
    CFG_POOL_ON     = 3'd4
  } cfg_idx_e;

  localparam logic [5:0] SecondsPerMinute = 6'd60;
  localparam logic [5:0] MinutesPerHour   = 6'd60;
  localparam logic [4:0] HoursPerDay      = 5'd24;

  localparam logic [4:0] DayHoursRst = 5'd12;
  localparam logic [7:0] OffMinRst   = 8'd30;
  localparam logic [7:0] OnMinRst    = 8'd10;

  // Running state of one pump.
  typedef struct packed {
    logic [7:0] minutes;
    logic       on;
  } pump_t;

  // Switching times of one pump.
  typedef struct packed {
    logic [7:0] off_min;
    logic [7:0] on_min;
  } pump_cfg_t;

endpackage

`default_nettype wire

// ===== src/plt_pump.sv =====
// Next-state logic of one pump: minute count and off/on alternation.
`default_nettype none

module plt_pump (
  input  logic              step_i,
  input  plt_pkg::pump_cfg_t cfg_i,
  input  plt_pkg::pump_t     cur_i,
  output plt_pkg::pump_t     nxt_o
);
  import plt_pkg::*;

  pump_t inc;
  pump_t mid;

  always_comb begin
    inc.minutes = cur_i.minutes + 8'd1;
    inc.on      = cur_i.on;

    // switch on first, then the off check sees the result
    mid = inc;
    if (inc.minutes == cfg_i.off_min && !inc.on) begin
      mid.on      = 1'b1;
      mid.minutes = 8'd0;
    end

    nxt_o = mid;
    if (mid.minutes == cfg_i.on_min && mid.on) begin
      nxt_o.on      = 1'b0;
      nxt_o.minutes = 8'd0;
    end

    if (!step_i) begin
      nxt_o = cur_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/pump_light_cycle_timer.sv =====
// A tick word accepted into the input register moves on into the result register once that is free or read.
// Throughput: one tick word per cycle while out_stall_i does not hold a result; input and result
// registers decouple the two channels, so one new word is taken while a result waits.
// The state update is one pass of short logic between the two registers.
// Reset (rst_ni low, asynchronous): counters and pump states clear, day phase,
// registers take their defaults; both channels empty.
`default_nettype none

module pump_light_cycle_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [plt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [plt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        running_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        pipe_pump_on_o,
  output logic                        pool_pump_on_o,
  output logic                        night_o,
  output logic                        light_clear_o
);
  import plt_pkg::*;

  // configuration
  logic [4:0] day_hours_q;
  pump_cfg_t  pipe_cfg_q, pool_cfg_q;

  // handshake
  logic in_vld_q, in_vld_d, in_run_q;
  logic out_vld_q, out_vld_d;
  logic load_in, adv;

  // timer state
  logic [5:0] sec_q, sec_d;
  logic [5:0] dmin_q, dmin_d;
  logic [7:0] hour_q, hour_d;
  logic       night_q, night_d;
  logic       clear_d, clear_q;
  pump_t      pipe_q, pipe_d, pool_q, pool_d;

  logic [5:0] sec_inc, dmin_inc;
  logic [7:0] hour_inc, hour_mid;
  logic       night_mid;
  logic       min_roll;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_hours_q <= DayHoursRst;
      pipe_cfg_q  <= '{off_min: OffMinRst, on_min: OnMinRst};
      pool_cfg_q  <= '{off_min: OffMinRst, on_min: OnMinRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DAY_HOURS: day_hours_q        <= cfg_data_i[4:0];
        CFG_PIPE_OFF:  pipe_cfg_q.off_min <= cfg_data_i;
        CFG_PIPE_ON:   pipe_cfg_q.on_min  <= cfg_data_i;
        CFG_POOL_OFF:  pool_cfg_q.off_min <= cfg_data_i;
        CFG_POOL_ON:   pool_cfg_q.on_min  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign load_in    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (load_in) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_comb begin
    sec_inc  = sec_q + 6'd1;
    dmin_inc = dmin_q + 6'd1;
    hour_inc = hour_q + 8'd1;
    min_roll = in_run_q && (sec_inc >= SecondsPerMinute);

    sec_d   = sec_q;
    dmin_d  = dmin_q;
    hour_d  = hour_q;
    night_d = night_q;
    clear_d = 1'b0;
    hour_mid  = hour_inc;
    night_mid = night_q;

    if (in_run_q) begin
      sec_d = min_roll ? 6'd0 : sec_inc;
    end
    if (min_roll) begin
      dmin_d = dmin_inc;
      if (dmin_inc >= MinutesPerHour) begin
        dmin_d = 6'd0;
        // enter night, then check for leaving it on the same count
        if (hour_inc == {3'b000, day_hours_q} && !night_q) begin
          hour_mid  = 8'd0;
          night_mid = 1'b1;
          clear_d   = 1'b1;
        end
        hour_d  = hour_mid;
        night_d = night_mid;
        if (day_hours_q <= HoursPerDay && night_mid &&
            hour_mid == {3'b000, HoursPerDay - day_hours_q}) begin
          hour_d  = 8'd0;
          night_d = 1'b0;
        end
      end
    end
  end

  plt_pump u_pipe (
    .step_i (min_roll),
    .cfg_i  (pipe_cfg_q),
    .cur_i  (pipe_q),
    .nxt_o  (pipe_d)
  );

  plt_pump u_pool (
    .step_i (min_roll),
    .cfg_i  (pool_cfg_q),
    .cur_i  (pool_q),
    .nxt_o  (pool_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      sec_q     <= '0;
      dmin_q    <= '0;
      hour_q    <= '0;
      night_q   <= 1'b0;
      pipe_q    <= '0;
      pool_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      // advance the timer only as a word moves into the result register
      if (adv) begin
        sec_q   <= sec_d;
        dmin_q  <= dmin_d;
        hour_q  <= hour_d;
        night_q <= night_d;
        pipe_q  <= pipe_d;
        pool_q  <= pool_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_run_q <= running_i;
    end
    if (adv) begin
      clear_q <= clear_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pipe_pump_on_o = pipe_q.on;
  assign pool_pump_on_o = pool_q.on;
  assign night_o        = night_q;
  assign light_clear_o  = clear_q;

`ifndef SYNTHESIS
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q < SecondsPerMinute && dmin_q < MinutesPerHour)
    else $error("seconds or day minutes out of range");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked word");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sec_q) && $stable(hour_q) && $stable(pipe_q) && $stable(pool_q))
    else $error("timer state moved without a word");

  a_clear_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && clear_q |-> hour_q == 8'd0 && dmin_q == 6'd0 && sec_q == 6'd0)
    else $error("light clear without fresh hour count");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(clear_q) && $stable(night_q))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_pump_light_cycle_timer.sv =====
// Self-checking testbench for the pump and light cycle timer.
module tb_pump_light_cycle_timer;
  timeunit 1ns;
  timeprecision 1ps;

  import plt_pkg::*;

  localparam int unsigned DrainCycles = 4;
  localparam int unsigned DrainLimit  = 1000;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned DirectedRun = 360;
  localparam int unsigned RandomItems = 975;
  localparam int unsigned WatchdogNs  = 2_000_000;

  typedef struct packed {
    logic pipe_on;
    logic pool_on;
    logic night;
    logic light_clear;
  } tick_result_t;

  typedef struct packed {
    logic         running;
    logic         typed;
    tick_result_t result;
  } tick_row_t;

  typedef struct {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [7:0] hours;
    logic       night;
    pump_t      pipe;
    pump_t      pool;
  } timer_state_t;

  localparam tick_result_t AllOff = '0;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                running_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                pipe_pump_on_o;
  logic                pool_pump_on_o;
  logic                night_o;
  logic                light_clear_o;

  // Shadow copy of the block's state and registers.
  timer_state_t timer;
  logic [4:0]   day_hours_cfg;
  pump_cfg_t    pipe_cfg;
  pump_cfg_t    pool_cfg;

  tick_result_t predicted_q[$];
  int unsigned  mismatch_count = 0;
  bit           idle_on = 1'b1;
  bit           hold_request = 1'b0;

  // Right after reset nothing can switch within a few seconds.
  tick_row_t directed_rows [16] = '{
    '{1'b0, 1'b1, AllOff}, '{1'b0, 1'b1, AllOff}, '{1'b1, 1'b1, AllOff},
    '{1'b1, 1'b1, AllOff}, '{1'b0, 1'b1, AllOff}, '{1'b1, 1'b1, AllOff},
    '{1'b1, 1'b1, AllOff}, '{1'b1, 1'b1, AllOff}, '{1'b0, 1'b1, AllOff},
    '{1'b1, 1'b1, AllOff}, '{1'b1, 1'b1, AllOff}, '{1'b0, 1'b1, AllOff},
    '{1'b1, 1'b0, AllOff}, '{1'b1, 1'b0, AllOff}, '{1'b1, 1'b0, AllOff},
    '{1'b1, 1'b0, AllOff}
  };

  pump_light_cycle_timer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .running_i      (running_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pipe_pump_on_o (pipe_pump_on_o),
    .pool_pump_on_o (pool_pump_on_o),
    .night_o        (night_o),
    .light_clear_o  (light_clear_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pump_t switch_pump(input pump_t p, input pump_cfg_t c);
    if (p.minutes == c.off_min && !p.on) begin
      p.on      = 1'b1;
      p.minutes = '0;
    end
    if (p.minutes == c.on_min && p.on) begin
      p.on      = 1'b0;
      p.minutes = '0;
    end
    return p;
  endfunction

  // Advance the shadow state by one tick word and return the outputs it shows.
  function automatic tick_result_t advance_timer(input logic run);
    tick_result_t r;
    r = AllOff;
    if (run) begin
      timer.seconds = timer.seconds + 6'd1;
      if (timer.seconds >= SecondsPerMinute) begin
        timer.seconds      = '0;
        timer.pipe.minutes = timer.pipe.minutes + 8'd1;
        timer.pool.minutes = timer.pool.minutes + 8'd1;
        timer.minutes      = timer.minutes + 6'd1;
        if (timer.minutes >= MinutesPerHour) begin
          timer.minutes = '0;
          timer.hours   = timer.hours + 8'd1;
          if (timer.hours == {3'b000, day_hours_cfg} && !timer.night) begin
            timer.hours   = '0;
            timer.night   = 1'b1;
            r.light_clear = 1'b1;
          end
          // Night never ends once day hours exceed a whole day.
          if (day_hours_cfg <= HoursPerDay && timer.night &&
              timer.hours == {3'b000, HoursPerDay - day_hours_cfg}) begin
            timer.hours = '0;
            timer.night = 1'b0;
          end
        end
        timer.pipe = switch_pump(timer.pipe, pipe_cfg);
        timer.pool = switch_pump(timer.pool, pool_cfg);
      end
    end
    r.pipe_on = timer.pipe.on;
    r.pool_on = timer.pool.on;
    r.night   = timer.night;
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return CfgDataW'($urandom_range(0, 3));
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic run, input bit given, input tick_result_t given_result);
    int unsigned  gap;
    tick_result_t predicted;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    running_i  <= run;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_timer(run);
    predicted_q.push_back(given ? given_result : predicted);
  endtask

  task automatic run_ticks(input int unsigned count, input int unsigned run_pct);
    for (int unsigned k = 0; k < count; k++) begin
      send_tick($urandom_range(0, 99) < run_pct, 1'b0, AllOff);
    end
  endtask

  // Write one register once the block has gone quiet.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DAY_HOURS: day_hours_cfg    = data[4:0];
      CFG_PIPE_OFF:  pipe_cfg.off_min = data;
      CFG_PIPE_ON:   pipe_cfg.on_min  = data;
      CFG_POOL_OFF:  pool_cfg.off_min = data;
      CFG_POOL_ON:   pool_cfg.on_min  = data;
      default: ;
    endcase
  endtask

  initial begin : result_sink
    string        names [4];
    tick_result_t seen;
    tick_result_t want;
    int unsigned  stall_left;
    int unsigned  hold_left;
    names      = '{"pipe_pump_on", "pool_pump_on", "night", "light_clear"};
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen = '{pipe_pump_on_o, pool_pump_on_o, night_o, light_clear_o};
        if (predicted_q.size() == 0) begin
          $error("result word with no expectation pending");
          mismatch_count++;
        end else begin
          want = predicted_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (seen[3-i] !== want[3-i]) begin
              $error("%s: expected %0b, got %0b", names[i], want[3-i], seen[3-i]);
              mismatch_count++;
            end
          end
        end
        stall_left = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left > 0 && out_valid_o) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned len;
    int unsigned waited;
    bit          first_phase;
    timer         = '{seconds: '0, minutes: '0, hours: '0, night: 1'b0,
                      pipe: '0, pool: '0};
    day_hours_cfg = DayHoursRst;
    pipe_cfg      = '{off_min: OffMinRst, on_min: OnMinRst};
    pool_cfg      = '{off_min: OffMinRst, on_min: OnMinRst};
    random_items  = 0;
    first_phase   = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].running, directed_rows[i].typed, directed_rows[i].result);
    end

    // Pipe switches on and off within one minute; pool cycles on, then off.
    write_reg(CFG_DAY_HOURS, 8'd1);
    write_reg(CFG_PIPE_OFF, 8'd1);
    write_reg(CFG_PIPE_ON, 8'd0);
    write_reg(CFG_POOL_OFF, 8'd2);
    write_reg(CFG_POOL_ON, 8'd3);
    idle_on = 1'b0;
    run_ticks(DirectedRun, 100);

    while (random_items < RandomItems) begin
      repeat ($urandom_range(1, 3)) begin
        write_reg(CfgIdxW'($urandom_range(0, (1 << CfgIdxW) - 1)), pick_value());
      end
      idle_on = ($urandom_range(0, 4) != 0);
      if (first_phase) begin
        idle_on      = 1'b1;
        hold_request = 1'b1;
        first_phase  = 1'b0;
      end
      len = $urandom_range(60, 240);
      if (len > RandomItems - random_items) begin
        len = RandomItems - random_items;
      end
      run_ticks(len, $urandom_range(40, 100));
      random_items += len;
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (predicted_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (predicted_q.size() != 0) begin
      $error("%0d expected result words never arrived", predicted_q.size());
      mismatch_count++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_pump_light_cycle_timer: clean");
    end else begin
      $display("tb_pump_light_cycle_timer: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(WatchdogNs);
    $display("tb_pump_light_cycle_timer: errors");
    $finish;
  end

endmodule
